### hw/rtl/wfba_pkg.sv
// Package for the worst-fit block allocator.
// Holds table sizes, opcodes, controller states and the command and status structs.
// No dependencies.
package wfba_pkg;

  localparam int NUM_BLOCKS = 16;
  localparam int SIZE_BITS  = 16;
  localparam int IDX_BITS   = $clog2(NUM_BLOCKS);
  localparam int CNT_BITS   = $clog2(NUM_BLOCKS + 1);

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_ALLOC = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_LAST   = 4'b0100,
    ST_COMMIT = 4'b1000
  } state_t;

  typedef struct packed {
    logic accept;
    logic issue;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic in_alloc;
    logic count_zero;
    logic scan_last;
    logic out_free;
  } status_t;

endpackage

### hw/rtl/wfba_ctrl.sv
// Controller state machine of the worst-fit block allocator.
// Sequences accept, table scan and commit; depends on wfba_pkg.
module wfba_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  wfba_pkg::status_t status,
  output wfba_pkg::cmd_t    cmd
);
  import wfba_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (status.in_alloc && !status.count_zero) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_COMMIT;
          end
        end
      end
      ST_SCAN: begin
        cmd.issue = 1'b1;
        if (status.scan_last) begin
          state_next = ST_LAST;
        end
      end
      ST_LAST: begin
        state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### hw/rtl/wfba_dp.sv
// Datapath of the worst-fit block allocator.
// Holds the size table, occupied flags, best-candidate tracking and the result register;
// depends on wfba_pkg.
module wfba_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  wfba_pkg::cmd_t                   cmd,
  output wfba_pkg::status_t                status,
  input  logic [wfba_pkg::CNT_BITS-1:0]    blocks_in_use,
  input  logic                             opcode,
  input  logic [3:0]                       block_index,
  input  logic [15:0]                      amount,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             granted,
  output logic [3:0]                       chosen_block,
  output logic [15:0]                      fragment
);
  import wfba_pkg::*;

  logic [SIZE_BITS-1:0] mem [NUM_BLOCKS];
  logic [NUM_BLOCKS-1:0] occupied;

  logic                 op;
  logic [SIZE_BITS-1:0] req;
  logic [CNT_BITS-1:0]  count;
  logic [IDX_BITS-1:0]  scan_idx;

  logic [SIZE_BITS-1:0] rd_data;
  logic [IDX_BITS-1:0]  rd_idx;
  logic                 rd_valid;

  logic                 found;
  logic [IDX_BITS-1:0]  best_idx;
  logic [SIZE_BITS-1:0] best_size;

  logic [CNT_BITS-1:0]  count_clamped;
  logic [SIZE_BITS-1:0] req_in;
  logic [IDX_BITS-1:0]  load_idx;
  logic                 fits;
  logic [SIZE_BITS-1:0] left;

  assign count_clamped = (blocks_in_use > CNT_BITS'(NUM_BLOCKS)) ?
                         CNT_BITS'(NUM_BLOCKS) : blocks_in_use;
  assign req_in   = SIZE_BITS'(amount);
  assign load_idx = IDX_BITS'(block_index);
  assign fits     = rd_valid && !occupied[rd_idx] && (rd_data >= req) &&
                    (!found || (best_size < rd_data));
  assign left     = best_size - req;

  assign status.in_alloc   = (opcode == OP_ALLOC);
  assign status.count_zero = (count_clamped == '0);
  assign status.scan_last  = ({1'b0, scan_idx} == CNT_BITS'(count - CNT_BITS'(1)));
  assign status.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.accept && (opcode == OP_LOAD)) begin
      mem[load_idx] <= req_in;
    end else if (cmd.commit && found) begin
      mem[best_idx] <= left;
    end
    rd_data <= mem[scan_idx];
    rd_idx  <= scan_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupied <= '0;
      rd_valid <= 1'b0;
      found    <= 1'b0;
      scan_idx <= '0;
    end else begin
      rd_valid <= cmd.issue;
      if (cmd.accept) begin
        found    <= 1'b0;
        scan_idx <= '0;
        if (opcode == OP_LOAD) begin
          occupied[load_idx] <= 1'b0;
        end
      end else begin
        if (cmd.issue) begin
          scan_idx <= scan_idx + IDX_BITS'(1);
        end
        if (fits) begin
          found <= 1'b1;
        end
        if (cmd.commit && found) begin
          occupied[best_idx] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op    <= opcode;
      req   <= req_in;
      count <= count_clamped;
    end
    if (fits) begin
      best_idx  <= rd_idx;
      best_size <= rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      granted      <= found && (op == OP_ALLOC);
      chosen_block <= found ? 4'(best_idx) : 4'd0;
      fragment     <= found ? 16'(left) : 16'd0;
    end
  end

endmodule

### hw/rtl/worst_fit_block_allocator_unit.sv
// Top level of the worst-fit block allocator.
// Holds the configuration register and joins wfba_ctrl and wfba_dp; depends on wfba_pkg.
//
// A load transaction writes one block size, clears its occupied flag and answers with a
// zero result. An allocate transaction reads the first min(blocks_in_use, 16) table
// entries one per cycle through the single read port of the size table, then passes
// through a last-compare state and a write-back state. A new transaction is accepted the
// cycle after the previous result has been placed in the output register, even while that
// result still waits to be taken; its own result then waits until the output register is
// free. Register blocks_in_use sits at byte address 0 of the APB port.
module worst_fit_block_allocator_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        opcode,
  input  logic [3:0]  block_index,
  input  logic [15:0] amount,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        granted,
  output logic [3:0]  chosen_block,
  output logic [15:0] fragment
);
  import wfba_pkg::*;

  logic [CNT_BITS-1:0] blocks_in_use;
  cmd_t                cmd;
  status_t             status;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      blocks_in_use <= CNT_BITS'(NUM_BLOCKS);
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      blocks_in_use <= pwdata[CNT_BITS-1:0];
    end
  end

  assign prdata = (paddr[2] == 1'b0) ? 32'(blocks_in_use) : 32'd0;

  wfba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  wfba_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .blocks_in_use (blocks_in_use),
    .opcode        (opcode),
    .block_index   (block_index),
    .amount        (amount),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .granted       (granted),
    .chosen_block  (chosen_block),
    .fragment      (fragment)
  );

endmodule
